@@ sv/wildcard_byte_pattern_scan_assert.svh @@
// Assertion macros shared by the scan block.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH

`ifndef SYNTHESIS

`define WBPS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define WBPS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define WBPS_ASSERT_IMP(name, clk, rst, ante, cons)

`define WBPS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

@@ sv/wbps_pkg.sv @@
`timescale 1ns / 1ps

package wbps_pkg;

   localparam int MAX_PATTERN_DEF  = 32;
   localparam int ADDRESS_BITS_DEF = 48;

   localparam int PATTERN_WORDS  = 4;
   localparam int WORD_BITS      = 64;
   localparam int MASK_BITS      = 32;
   localparam int LENGTH_BITS    = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PAT_INDEX_BITS = 5;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_3 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WILDCARD  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LENGTH    = 3'd5;

   typedef logic [PATTERN_WORDS-1:0][WORD_BITS-1:0] pattern_words_type;

   // Pattern byte and wildcard flag that a window cell compares against.
   typedef struct packed {
      logic [7:0] pattern;
      logic       wild;
      logic       active;
   } cell_cfg_type;

   function automatic logic [7:0] pattern_byte(input pattern_words_type words,
                                               input logic [PAT_INDEX_BITS-1:0] idx);
      return words[idx[4:3]][{idx[2:0], 3'b000} +: 8];
   endfunction

endpackage

@@ sv/wbps_cell.sv @@
`timescale 1ns / 1ps

module wbps_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  logic [7:0]            link_data,
   input  logic                  link_valid,
   input  wbps_pkg::cell_cfg_type cfg,
   output logic [7:0]            data_q,
   output logic                  valid_q,
   output logic                  match
);
   import wbps_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       valid_ff;
   logic       valid_in;

   assign data_in  = shift ? link_data  : data_ff;
   assign valid_in = shift ? link_valid : valid_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data_q  = data_ff;
   assign valid_q = valid_ff;

   // The compare looks at the byte this cell takes in on the current shift.
   assign match = !cfg.active || (link_valid && (cfg.wild || link_data == cfg.pattern));

endmodule

@@ sv/wildcard_byte_pattern_scan.sv @@
// An accepted item's result lands in the output register on the next cycle.
// Throughput: one item per cycle unless stalled; the window's chained byte
// cells all shift and compare in the same cycle, so no item waits on another.
// Input stall is raised only while a result is held and the output is stalled.
// Reset (synchronous, active high) empties the window, clears the found record
// and loads a pattern of length one with all bytes zero and no wildcards.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_assert.svh"

module wildcard_byte_pattern_scan #(
   parameter int MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEF,
   parameter int ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic [ADDRESS_BITS-1:0]           req_byte_address,
   input  logic                              req_region_start,
   input  logic                              req_new_search,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [ADDRESS_BITS-1:0]           rsp_hit_address,
   output logic                              rsp_found,
   output logic [ADDRESS_BITS-1:0]           rsp_first_address,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wbps_pkg::WORD_BITS-1:0]    csr_wdata
);
   import wbps_pkg::*;

   pattern_words_type       pattern_ff;
   logic [MASK_BITS-1:0]    mask_ff;
   logic [LENGTH_BITS-1:0]  length_ff;
   logic [LENGTH_BITS-1:0]  len_used;

   logic                    accept;
   logic                    csr_write;

   logic [7:0]              cell_data  [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]  cell_valid;
   logic [MAX_PATTERN-1:0]  cell_match;
   cell_cfg_type            cell_cfg   [MAX_PATTERN];

   logic                    hit_now;
   logic [ADDRESS_BITS-1:0] start_addr;
   logic                    found_base;
   logic [ADDRESS_BITS-1:0] first_base;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_hit_ff;
   logic [ADDRESS_BITS-1:0] rsp_hit_address_ff;
   logic                    found_ff;
   logic                    found_in;
   logic [ADDRESS_BITS-1:0] first_ff;
   logic [ADDRESS_BITS-1:0] first_in;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         mask_ff    <= '0;
         length_ff  <= LENGTH_BITS'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_PATTERN_0: pattern_ff[0] <= csr_wdata;
            REG_PATTERN_1: pattern_ff[1] <= csr_wdata;
            REG_PATTERN_2: pattern_ff[2] <= csr_wdata;
            REG_PATTERN_3: pattern_ff[3] <= csr_wdata;
            REG_WILDCARD:  mask_ff       <= csr_wdata[MASK_BITS-1:0];
            REG_LENGTH:    length_ff     <= csr_wdata[LENGTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      len_used = length_ff;
      if (length_ff == '0) begin
         len_used = LENGTH_BITS'(1);
      end else if (length_ff > LENGTH_BITS'(MAX_PATTERN)) begin
         len_used = LENGTH_BITS'(MAX_PATTERN);
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Window chain: cell k takes in the byte of age k. Cell k compares against
   // pattern byte (length - 1 - k), so the newest byte meets the last one.
   genvar k;
   generate
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         logic [LENGTH_BITS-1:0] pat_idx;
         logic [7:0]             link_data;
         logic                   link_valid;

         assign pat_idx = len_used - LENGTH_BITS'(1) - LENGTH_BITS'(k);

         assign cell_cfg[k].pattern = pattern_byte(pattern_ff, pat_idx[PAT_INDEX_BITS-1:0]);
         assign cell_cfg[k].wild    = mask_ff[pat_idx[PAT_INDEX_BITS-1:0]];
         assign cell_cfg[k].active  = LENGTH_BITS'(k) < len_used;

         if (k == 0) begin : g_head
            assign link_data  = req_data_byte;
            assign link_valid = 1'b1;
         end else begin : g_body
            assign link_data  = cell_data[k-1];
            assign link_valid = cell_valid[k-1] && !req_region_start;
         end

         wbps_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift      (accept),
            .link_data  (link_data),
            .link_valid (link_valid),
            .cfg        (cell_cfg[k]),
            .data_q     (cell_data[k]),
            .valid_q    (cell_valid[k]),
            .match      (cell_match[k])
         );
      end
   endgenerate

   assign hit_now    = &cell_match;
   assign start_addr = req_byte_address
                       - ADDRESS_BITS'(len_used - LENGTH_BITS'(1));

   // Sticky first-match record.
   always_comb begin
      found_base = req_new_search ? 1'b0 : found_ff;
      first_base = req_new_search ? '0   : first_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      if (accept) begin
         found_in = found_base;
         first_in = first_base;
         if (hit_now && !found_base) begin
            found_in = 1'b1;
            first_in = start_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         first_ff <= '0;
      end else begin
         found_ff <= found_in;
         first_ff <= first_in;
      end
   end

   // Output register; the found record doubles as the result's sticky fields.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff         <= hit_now;
         rsp_hit_address_ff <= hit_now ? start_addr : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_hit_address   = rsp_hit_address_ff;
   assign rsp_found         = found_ff;
   assign rsp_first_address = first_ff;

   `WBPS_ASSERT_NXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   `WBPS_ASSERT_IMP(a_hit_sets_found, clock, reset, rsp_valid_ff && rsp_hit_ff, found_ff)
   `WBPS_ASSERT_IMP(a_no_hit_zero_addr, clock, reset, rsp_valid_ff && !rsp_hit_ff,
                    rsp_hit_address_ff == '0)
   `WBPS_ASSERT_IMP(a_not_found_zero_first, clock, reset, !found_ff, first_ff == '0)
   `WBPS_ASSERT_NXT(a_region_blocks_long_hit, clock, reset,
                    accept && req_region_start && len_used != LENGTH_BITS'(1), !rsp_hit_ff)

endmodule
